@@ src/hsw_pkg.sv @@
package hsw_pkg;

   // Field and register widths
   localparam int VAL_W     = 24;
   localparam int COEF_W    = 16;
   localparam int ROW_OUT_W = 4;
   localparam int CSR_IDX_W = 1;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING = 1'd1;
   localparam logic [COEF_W-1:0]    GRAVITY_RST = 16'd2248;
   localparam logic [COEF_W-1:0]    DAMPING_RST = 16'd65470;

   // Saturation limits of a displacement
   localparam logic [VAL_W-1:0] VAL_MAX_C = 24'h7fffff;
   localparam logic [VAL_W-1:0] VAL_MIN_C = 24'h800000;

   // How a row's new value is formed
   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_TOP,
      KIND_INNER,
      KIND_BOTTOM
   } kind_type;

   // Tick sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

endpackage

@@ src/hsw_update.sv @@
module hsw_update import hsw_pkg::*; #(
   parameter int W_WIDTH = 33
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic                      push,
   input  kind_type                  kind,
   input  logic signed [W_WIDTH-1:0] w,
   input  logic signed [VAL_W-1:0]   u,
   input  logic signed [VAL_W-1:0]   p,
   input  logic signed [VAL_W-1:0]   drive,
   input  logic [COEF_W-1:0]         gravity,
   input  logic [COEF_W-1:0]         damping,
   output logic [VAL_W-1:0]          value
);

   localparam int AD = W_WIDTH + 18;
   localparam int SW = W_WIDTH + 1;

   logic signed [W_WIDTH+16:0] cw;
   logic signed [AD-1:0]       acc;
   logic signed [SW-1:0]       s_ff;
   kind_type                   kind_ff;
   logic signed [SW+16:0]      prod;
   logic signed [SW+16:0]      rnd;
   logic signed [SW:0]         q;
   logic [SW-23:0]             q_hi;
   logic [VAL_W-1:0]           inner_val;
   logic signed [VAL_W+1:0]    extra;
   logic [VAL_W-1:0]           bottom_val;
   logic [VAL_W-1:0]           n1_ff;
   logic [VAL_W-1:0]           n2_ff;

   // Stencil sum in Q.17 scale, rounded half up into the s stage
   assign cw  = $signed({1'b0, gravity}) * w;
   assign acc = {{(AD-W_WIDTH-17){cw[W_WIDTH+16]}}, cw}
              + {{(AD-42){u[VAL_W-1]}}, u, 18'd0}
              - {{(AD-41){p[VAL_W-1]}}, p, 17'd0}
              + AD'(65536);

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= acc[AD-1:17];
         kind_ff <= kind;
      end
   end

   // Damp, round half up, saturate
   assign prod = s_ff * $signed({1'b0, damping});
   assign rnd  = prod + (SW+17)'(32768);
   assign q    = rnd[SW+16:16];
   assign q_hi = q[SW:23];

   always_comb begin
      if ((&q_hi) || !(|q_hi)) begin
         inner_val = q[VAL_W-1:0];
      end else if (q[SW]) begin
         inner_val = VAL_MIN_C;
      end else begin
         inner_val = VAL_MAX_C;
      end
   end

   // Linear extrapolation of the bottom row from the two rows above
   assign extra = {n1_ff[VAL_W-1], n1_ff, 1'b0} - {{2{n2_ff[VAL_W-1]}}, n2_ff};

   always_comb begin
      if (extra[VAL_W+1:VAL_W-1] == 3'b000 || extra[VAL_W+1:VAL_W-1] == 3'b111) begin
         bottom_val = extra[VAL_W-1:0];
      end else if (extra[VAL_W+1]) begin
         bottom_val = VAL_MIN_C;
      end else begin
         bottom_val = VAL_MAX_C;
      end
   end

   // Select the row's value
   always_comb begin
      case (kind_ff)
         KIND_LOAD:   value = drive;
         KIND_TOP:    value = drive;
         KIND_INNER:  value = inner_val;
         KIND_BOTTOM: value = bottom_val;
         default:     value = drive;
      endcase
   end

   // Hold the last two emitted rows
   always_ff @(posedge clock) begin
      if (push) begin
         n1_ff <= value;
         n2_ff <= n1_ff;
      end
   end

endmodule

@@ src/hanging_string_wave_step.sv @@
// Hanging string wave step: one column of an explicit finite-difference string.
// req_ carries one word per time tick: the driven top displacement and a start
// flag in tuser. A start tick loads both stored layers with the drive value;
// any other tick computes the new layer from the current and previous layers.
// rsp_ returns one word per row, row 0 first, tlast on the bottom row.
// The layers live in two RAMs with a read port and a separate write port, read in
// row order, one row a cycle while the output is not stalled, and rewritten as the
// results leave the arithmetic pipeline. Each row passes the RAM read, stage 2
// and stage 3 registers into the output register; rows then leave one a cycle
// while rsp_tready is high. A new tick is accepted only after the row sweep has
// issued every row and the pipeline has drained, so the next tick reads the
// rewritten layers.
// A stalled receiver freezes the whole row pipeline, RAM reads included; the
// final word is held in the output register while the next tick is accepted.
// Reset sets both coefficient registers to their defaults and marks every row
// invalid, so both layers read as zero until written.
// csr_ writes take effect at once and should only occur while the block is idle.
module hanging_string_wave_step import hsw_pkg::*; #(
   parameter int ROWS = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [COEF_W-1:0]    csr_wdata,
   // tick input
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [23:0] drive_value
   input  logic                 req_tuser,   // [0] start_tick
   // row results
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // [3:0] node_row, [27:4] node_value, zero pad
   output logic                 rsp_tlast    // last_row
);

   localparam int AW = $clog2(ROWS);
   localparam int JW = $clog2(ROWS + 1);
   localparam int MW = $clog2(2 * ROWS);
   localparam int WW = MW + 28;

   // Coefficients
   logic [COEF_W-1:0] gravity_ff;
   logic [COEF_W-1:0] damping_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= GRAVITY_RST;
         damping_ff <= DAMPING_RST;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_GRAVITY: gravity_ff <= csr_wdata;
            CSR_DAMPING: damping_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer
   state_type               state_ff, state_in;
   logic [JW-1:0]           j_ff, j_in;
   logic                    issue;
   logic                    adv;
   logic                    req_fire;
   logic signed [VAL_W-1:0] drive_ff;
   logic                    start_ff;
   logic                    s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic                    rsp_vld_ff;

   assign adv      = !rsp_vld_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      j_in       = j_ff;
      req_tready = 1'b0;
      issue      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_ISSUE;
               j_in     = '0;
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            if (adv) begin
               j_in = j_ff + 1'b1;
               if (j_ff == JW'(ROWS)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff && !s3_vld_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Latch the tick
   always_ff @(posedge clock) begin
      if (req_fire) begin
         drive_ff <= req_tdata;
         start_ff <= req_tuser;
      end
   end

   // Layer RAMs with per-row valid bits
   logic signed [VAL_W-1:0] cur_mem [ROWS];
   logic signed [VAL_W-1:0] prv_mem [ROWS];
   logic [ROWS-1:0]         row_vld_ff;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic signed [VAL_W-1:0] cur_rd_ff, prv_rd_ff;
   logic                    rd_vld_ff;
   logic [JW-1:0]           s1_j_ff;
   logic                    push;
   logic [AW-1:0]           s3_row_ff;
   logic signed [VAL_W-1:0] s3_pw_ff;
   logic [VAL_W-1:0]        new_val;

   assign rd_en   = issue && adv && (j_ff != JW'(ROWS));
   assign rd_addr = j_ff[AW-1:0];
   assign push    = adv && s3_vld_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         cur_rd_ff <= cur_mem[rd_addr];
         prv_rd_ff <= prv_mem[rd_addr];
         rd_vld_ff <= row_vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cur_mem[s3_row_ff] <= new_val;
         prv_mem[s3_row_ff] <= s3_pw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (push) begin
         row_vld_ff[s3_row_ff] <= 1'b1;
      end
   end

   // Pipeline valids and issue slot
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= issue;
         s2_vld_ff  <= s1_vld_ff && (s1_j_ff != '0);
         s3_vld_ff  <= s2_vld_ff;
         rsp_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && issue) begin
         s1_j_ff <= j_ff;
      end
   end

   // Row window: u[j-2], u[j-1], p[j-1]
   logic signed [VAL_W-1:0] um2_ff, um1_ff, pm1_ff;
   logic signed [VAL_W-1:0] u_cur, p_cur;

   assign u_cur = rd_vld_ff ? cur_rd_ff : '0;
   assign p_cur = rd_vld_ff ? prv_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (adv && s1_vld_ff) begin
         um2_ff <= um1_ff;
         um1_ff <= u_cur;
         pm1_ff <= p_cur;
      end
   end

   // Weighted curvature term for row j-1: 2m*(above+below-2u) + (above-below)
   logic signed [VAL_W+1:0] lap;
   logic signed [VAL_W:0]   diff;
   logic [MW-1:0]           twom;
   logic signed [MW+26:0]   grad;
   logic signed [WW-1:0]    w_s1;
   kind_type                kind_s1;

   assign lap  = {{2{um2_ff[VAL_W-1]}}, um2_ff} + {{2{u_cur[VAL_W-1]}}, u_cur}
               - {um1_ff[VAL_W-1], um1_ff, 1'b0};
   assign diff = {um2_ff[VAL_W-1], um2_ff} - {u_cur[VAL_W-1], u_cur};
   assign twom = MW'(2 * (ROWS - int'(s1_j_ff)));
   assign grad = $signed({1'b0, twom}) * lap;
   assign w_s1 = {grad[MW+26], grad} + {{(WW-VAL_W-1){diff[VAL_W]}}, diff};

   always_comb begin
      if (start_ff) begin
         kind_s1 = KIND_LOAD;
      end else if (s1_j_ff == JW'(1)) begin
         kind_s1 = KIND_TOP;
      end else if (s1_j_ff == JW'(ROWS)) begin
         kind_s1 = KIND_BOTTOM;
      end else begin
         kind_s1 = KIND_INNER;
      end
   end

   // Stage 2 registers
   logic signed [WW-1:0]    s2_w_ff;
   logic signed [VAL_W-1:0] s2_u_ff, s2_p_ff, s2_pw_ff;
   kind_type                s2_kind_ff;
   logic [AW-1:0]           s2_row_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_w_ff    <= w_s1;
         s2_u_ff    <= um1_ff;
         s2_p_ff    <= pm1_ff;
         s2_pw_ff   <= start_ff ? drive_ff : um1_ff;
         s2_kind_ff <= kind_s1;
         s2_row_ff  <= AW'(s1_j_ff - 1'b1);
      end
   end

   // Stage 3: row tag and previous-layer write value
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_row_ff <= s2_row_ff;
         s3_pw_ff  <= s2_pw_ff;
      end
   end

   hsw_update #(
      .W_WIDTH (WW)
   ) u_update (
      .clock   (clock),
      .en      (adv),
      .push    (push),
      .kind    (s2_kind_ff),
      .w       (s2_w_ff),
      .u       (s2_u_ff),
      .p       (s2_p_ff),
      .drive   (drive_ff),
      .gravity (gravity_ff),
      .damping (damping_ff),
      .value   (new_val)
   );

   // Output register
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic [VAL_W-1:0]     rsp_val_ff;
   logic                 rsp_last_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_row_ff  <= ROW_OUT_W'(s3_row_ff);
         rsp_val_ff  <= new_val;
         rsp_last_ff <= (s3_row_ff == AW'(ROWS - 1));
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {4'd0, rsp_val_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sim/hanging_string_wave_step_test.sv @@
`timescale 1ns / 100ps

module hanging_string_wave_step_test;
   import hsw_pkg::*;

   localparam int ROWS_N       = 15;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 40;
   localparam int PHASES       = 7;
   localparam int PHASE_TICKS  = 50;

   // One row word as the block should return it
   typedef struct {
      logic [ROW_OUT_W-1:0] row;
      logic [VAL_W-1:0]     value;
      logic                 last;
   } row_word_t;

   // String column predictor and queue of expected row words
   class string_scoreboard;
      logic signed [VAL_W-1:0] cur_layer [ROWS_N];
      logic signed [VAL_W-1:0] prev_layer[ROWS_N];
      logic [COEF_W-1:0]       gravity;
      logic [COEF_W-1:0]       damping;
      row_word_t               expected_rows[$];
      int                      failures;
      int                      words_checked;

      function void reset_state();
         gravity = GRAVITY_RST;
         damping = DAMPING_RST;
         for (int i = 0; i < ROWS_N; i++) begin
            cur_layer[i]  = '0;
            prev_layer[i] = '0;
         end
         expected_rows.delete();
         failures      = 0;
         words_checked = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
         case (idx)
            CSR_GRAVITY: gravity = val;
            CSR_DAMPING: damping = val;
            default: ;
         endcase
      endfunction

      function longint clamp24(longint v);
         if (v > 64'sd8388607) return 64'sd8388607;
         if (v < -64'sd8388608) return -64'sd8388608;
         return v;
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction

      // Advance the column by one tick and queue the new layer, top row first
      function void note_tick(logic [VAL_W-1:0] drive, logic start);
         longint    fresh[ROWS_N];
         longint    c, d, m, acc, scaled;
         row_word_t w;
         c = longint'(gravity);
         d = longint'(damping);
         if (start) begin
            for (int i = 0; i < ROWS_N; i++) begin
               cur_layer[i]  = drive;
               prev_layer[i] = drive;
               fresh[i]      = longint'($signed(drive));
            end
         end else begin
            fresh[0] = longint'($signed(drive));
            for (int i = 1; i < ROWS_N - 1; i++) begin
               m   = ROWS_N - 1 - i;
               acc = 4 * (65536 - c * m) * longint'(cur_layer[i])
                   + c * (2 * m + 1) * longint'(cur_layer[i-1])
                   + c * (2 * m - 1) * longint'(cur_layer[i+1])
                   - 131072 * longint'(prev_layer[i]);
               // round half up at each rescale
               scaled   = (acc + 65536) >>> 17;
               fresh[i] = clamp24((scaled * d + 32768) >>> 16);
            end
            // bottom row: linear extrapolation, no damping
            fresh[ROWS_N-1] = clamp24(2 * fresh[ROWS_N-2] - fresh[ROWS_N-3]);
            for (int i = 0; i < ROWS_N; i++) begin
               prev_layer[i] = cur_layer[i];
               cur_layer[i]  = fresh[i][VAL_W-1:0];
            end
         end
         for (int i = 0; i < ROWS_N; i++) begin
            w.row   = i[ROW_OUT_W-1:0];
            w.value = fresh[i][VAL_W-1:0];
            w.last  = (i == ROWS_N - 1);
            expected_rows.push_back(w);
         end
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failures++;
         end
      endfunction

      // Match one returned word against the oldest expected row
      function void check_word(logic [31:0] tdata, logic tlast);
         row_word_t want;
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected row word, expected none, actual tdata %h tlast %b",
                     $time, tdata, tlast);
            failures++;
            return;
         end
         want = expected_rows.pop_front();
         words_checked++;
         compare_field("node_row", want.row, tdata[3:0]);
         compare_field("node_value", want.value, tdata[27:4]);
         compare_field("pad bits", 0, tdata[31:28]);
         compare_field("last_row", want.last, tlast);
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr   = '0;
   logic [COEF_W-1:0]    csr_wdata  = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata  = '0;   // [23:0] drive_value
   logic                 req_tuser  = 1'b0; // [0] start_tick
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;         // [3:0] node_row, [27:4] node_value, zero pad
   logic                 rsp_tlast;         // last_row

   string_scoreboard board;
   bit               calm         = 1'b0;
   bit               hold_request = 1'b0;
   int               quiet_cycles = 0;
   int               ticks_sent   = 0;
   int               starts_sent  = 0;
   int               settings_used = 0;

   hanging_string_wave_step #(.ROWS(ROWS_N)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit take_gap();
      return !calm && ($urandom_range(0, 99) < 18);
   endfunction

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_tready <= !take_gap();
            @(negedge clock);
         end
      end
   end

   // Check every accepted row word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_word(rsp_tdata, rsp_tlast);
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one tick word and hold it until accepted
   task automatic send_tick(input logic [VAL_W-1:0] drive, input logic start);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= drive;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      board.note_tick(drive, start);
      ticks_sent++;
      if (start) starts_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected row word has come back
   task automatic drain_rows();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0) @(negedge clock);
   endtask

   task automatic set_coefficients(input logic [COEF_W-1:0] grav,
                                   input logic [COEF_W-1:0] damp);
      csr_wr_en <= 1'b1;
      csr_addr  <= CSR_GRAVITY;
      csr_wdata <= grav;
      @(negedge clock);
      csr_addr  <= CSR_DAMPING;
      csr_wdata <= damp;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_register(CSR_GRAVITY, grav);
      board.set_register(CSR_DAMPING, damp);
      settings_used++;
   endtask

   // Mostly start-then-run sequences with a walking drive, some noise words
   task automatic run_random_phase(input int count);
      int               sent;
      int               run_len;
      int               level;
      logic [31:0]      noise;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            noise = $urandom;
            send_tick(noise[VAL_W-1:0], noise[31]);
            sent++;
         end else begin
            level = $urandom_range(0, 1 << 21) - (1 << 20);
            send_tick(level[VAL_W-1:0], 1'b1);
            sent++;
            run_len = $urandom_range(4, 24);
            for (int k = 0; k < run_len && sent < count; k++) begin
               level += $urandom_range(0, 16383) - 8192;
               send_tick(level[VAL_W-1:0], 1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [COEF_W-1:0] grav;
      logic [COEF_W-1:0] damp;
      board = new;
      board.reset_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset coefficients: ticks from the all-zero column, extremes of drive
      send_tick(24'h000000, 1'b0);
      send_tick(24'h7fffff, 1'b0);
      send_tick(24'h800000, 1'b0);
      // start tick, then the first tick after it (bottom extrapolation)
      send_tick(24'h7fffff, 1'b1);
      send_tick(24'h7fffff, 1'b0);
      send_tick(24'h800000, 1'b0);
      send_tick(24'h800000, 1'b1);
      send_tick(24'h000000, 1'b0);
      send_tick(24'h000001, 1'b0);
      send_tick(24'hffffff, 1'b0);

      // full-scale coefficients: push rows into saturation both ways
      drain_rows();
      set_coefficients(16'hffff, 16'hffff);
      send_tick(24'h400000, 1'b1);
      send_tick(24'h7fffff, 1'b0);
      send_tick(24'h800000, 1'b0);
      send_tick(24'h123456, 1'b0);

      // zero coefficients: inner rows collapse to zero
      drain_rows();
      set_coefficients(16'h0000, 16'h0000);
      send_tick(24'h7fffff, 1'b1);
      send_tick(24'h7fffff, 1'b0);
      send_tick(24'h800000, 1'b0);

      // no gravity, full damping factor: pure time extrapolation
      drain_rows();
      set_coefficients(16'h0000, 16'hffff);
      send_tick(24'h001000, 1'b1);
      send_tick(24'h002000, 1'b0);
      send_tick(24'hffe000, 1'b0);

      // random phases, one coefficient setting each
      for (int p = 0; p < PHASES; p++) begin
         drain_rows();
         case (p)
            0: begin grav = GRAVITY_RST; damp = DAMPING_RST; end
            1: begin grav = $urandom_range(0, 8191); damp = $urandom_range(60000, 65535); end
            2: begin grav = 16'hffff; damp = 16'h0000; end
            4: begin grav = 16'h0001; damp = 16'hffff; end
            6: begin grav = 16'h0000; damp = 16'h0001; end
            default: begin grav = $urandom_range(0, 65535); damp = $urandom_range(0, 65535); end
         endcase
         set_coefficients(grav, damp);
         calm = (p == 0);
         if (p == 1) hold_request = 1'b1;
         run_random_phase(PHASE_TICKS);
      end
      calm = 1'b0;

      drain_rows();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d ticks (%0d start ticks) under the reset and %0d written settings,",
               ticks_sent, starts_sent, settings_used);
      $display("including saturation, a long receiver hold-off; %0d row words checked.",
               board.words_checked);
      if (board.failures == 0 && board.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
src/hsw_pkg.sv
src/hsw_update.sv
src/hanging_string_wave_step.sv
sim/hanging_string_wave_step_test.sv
